// ===== rtl/core/cpe_pkg.sv =====
// Shared widths, register indexes and controller/datapath interface types.
package cpe_pkg;

   localparam int ROW_W         = 6;
   localparam int COL_W         = 7;
   localparam int PAGE_W        = 3;
   localparam int BYTE_W        = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int ROWS_PER_PAGE = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHTNESS_STEP = 2'd1;

   localparam logic [COL_W-1:0]  COLUMN_OFFSET_RST   = 7'd30;
   localparam logic [BYTE_W-1:0] BRIGHTNESS_STEP_RST = 8'd51;

   localparam logic KIND_CELL   = 1'b0;
   localparam logic KIND_BRIGHT = 1'b1;

   typedef struct packed {
      logic clear_wr;
      logic latch;
      logic store;
      logic toggle;
      logic rd_new;
      logic rd_old;
      logic load_new;
      logic load_old;
      logic load_brt;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic move;
      logic bright;
      logic changed;
   } status_type;

endpackage

// ===== rtl/core/cpe_ctrl.sv =====
// Sequencer for frame clear, store, frame reads and result beats.
module cpe_ctrl
   import cpe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_DISPATCH = 9'b000000100,
      ST_STORE    = 9'b000001000,
      ST_READ_NEW = 9'b000010000,
      ST_LOAD_NEW = 9'b000100000,
      ST_EMIT_NEW = 9'b001000000,
      ST_EMIT_OLD = 9'b010000000,
      ST_EMIT_BRT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.move) begin
               state_in = ST_STORE;
            end else begin
               cmd.toggle = 1'b1;
               if (status.bright) begin
                  cmd.load_brt = 1'b1;
                  state_in     = ST_EMIT_BRT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STORE: begin
            cmd.store  = 1'b1;
            cmd.toggle = 1'b1;
            state_in   = ST_READ_NEW;
         end
         ST_READ_NEW: begin
            cmd.rd_new = 1'b1;
            state_in   = ST_LOAD_NEW;
         end
         ST_LOAD_NEW: begin
            cmd.load_new = 1'b1;
            cmd.rd_old   = 1'b1;
            state_in     = ST_EMIT_NEW;
         end
         ST_EMIT_NEW: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.changed) begin
                  cmd.load_old = 1'b1;
                  state_in     = ST_EMIT_OLD;
               end else if (status.bright) begin
                  cmd.load_brt = 1'b1;
                  state_in     = ST_EMIT_BRT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_OLD: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.bright) begin
                  cmd.load_brt = 1'b1;
                  state_in     = ST_EMIT_BRT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT_BRT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/core/cpe_datapath.sv =====
// Frame store, cursor state, config registers and result registers.
module cpe_datapath
   import cpe_pkg::*;
#(
   parameter int NUM_COLUMNS = 102,
   parameter int NUM_PAGES   = 8,
   parameter int START_ROW   = 0,
   parameter int START_COL   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_up_pressed,
   input  logic                 req_down_pressed,
   input  logic                 req_left_pressed,
   input  logic                 req_right_pressed,
   input  logic                 req_draw_toggle,
   input  logic                 req_bright_press,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_kind,
   output logic [PAGE_W-1:0]    rsp_page,
   output logic [BYTE_W-1:0]    rsp_column,
   output logic [BYTE_W-1:0]    rsp_pixels,
   output logic [BYTE_W-1:0]    rsp_brightness,
   output logic                 rsp_last
);

   localparam int DEPTH      = NUM_COLUMNS * NUM_PAGES;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LAST_ROW_I = NUM_PAGES * ROWS_PER_PAGE - 1;
   localparam int LAST_COL_I = NUM_COLUMNS - 1;
   localparam int START_ROW_C = (START_ROW > LAST_ROW_I) ? LAST_ROW_I : START_ROW;
   localparam int START_COL_C = (START_COL > LAST_COL_I) ? LAST_COL_I : START_COL;

   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(LAST_ROW_I);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(LAST_COL_I);
   localparam logic [ROW_W-1:0]  START_ROWV = ROW_W'(START_ROW_C);
   localparam logic [COL_W-1:0]  START_COLV = COL_W'(START_COL_C);
   localparam logic [BYTE_W-1:0] START_BYTE = BYTE_W'(1 << (START_ROW_C % ROWS_PER_PAGE));
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      return ADDR_W'(col) * ADDR_W'(NUM_PAGES) + ADDR_W'(row[ROW_W-1:ROW_W-PAGE_W]);
   endfunction

   logic [BYTE_W-1:0] frame_mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              wr_en, rd_en;

   logic [ROW_W-1:0]  cursor_row_ff, cursor_row_in, old_row_ff;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in, old_col_ff;
   logic [BYTE_W-1:0] cursor_byte_ff, cursor_byte_in;
   logic              draw_mode_ff, draw_mode_in;
   logic [BYTE_W-1:0] bright_level_ff, bright_level_in;
   logic [COL_W-1:0]  column_offset_ff;
   logic [BYTE_W-1:0] brightness_step_ff;

   logic up_ff, down_ff, left_ff, right_ff, toggle_ff, bright_ff;
   logic [ROW_W-1:0]  next_row;
   logic [COL_W-1:0]  next_col;
   logic              changed;
   logic [BYTE_W-1:0] new_pixels;

   logic              kind_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [BYTE_W-1:0] column_ff, pixels_ff, brightness_ff;
   logic              last_ff;

   // frame store: one write and one registered read per cycle
   assign wr_en   = cmd.clear_wr | (cmd.store & draw_mode_ff);
   assign wr_addr = cmd.clear_wr ? clr_cnt_ff : cell_addr(cursor_col_ff, cursor_row_ff);
   assign wr_data = cmd.clear_wr ? '0 : cursor_byte_ff;
   assign rd_en   = cmd.rd_new | cmd.rd_old;
   assign rd_addr = cmd.rd_new ? cell_addr(cursor_col_ff, cursor_row_ff)
                               : cell_addr(old_col_ff, old_row_ff);

   always_ff @(posedge clock) begin
      if (wr_en) frame_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= frame_mem[rd_addr];
   end

   assign clr_cnt_in = cmd.clear_wr ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   // move with priority up, down, left, right, clamped
   always_comb begin
      next_row = cursor_row_ff;
      next_col = cursor_col_ff;
      if (up_ff) begin
         if (cursor_row_ff != '0) next_row = cursor_row_ff - 1'b1;
      end else if (down_ff) begin
         if (cursor_row_ff < LAST_ROW) next_row = cursor_row_ff + 1'b1;
      end else if (left_ff) begin
         if (cursor_col_ff != '0) next_col = cursor_col_ff - 1'b1;
      end else begin
         if (cursor_col_ff < LAST_COL) next_col = cursor_col_ff + 1'b1;
      end
   end

   assign changed = (cursor_row_ff[ROW_W-1:ROW_W-PAGE_W] != old_row_ff[ROW_W-1:ROW_W-PAGE_W])
                  || (cursor_col_ff != old_col_ff);
   assign new_pixels = (BYTE_W'(1) << cursor_row_ff[ROW_W-PAGE_W-1:0]) | rd_data_ff;

   assign cursor_row_in   = cmd.store ? next_row : cursor_row_ff;
   assign cursor_col_in   = cmd.store ? next_col : cursor_col_ff;
   assign cursor_byte_in  = cmd.load_new ? new_pixels : cursor_byte_ff;
   assign draw_mode_in    = draw_mode_ff ^ (cmd.toggle & toggle_ff);
   assign bright_level_in = cmd.load_brt ? bright_level_ff + brightness_step_ff
                                         : bright_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff         <= '0;
         cursor_row_ff      <= START_ROWV;
         cursor_col_ff      <= START_COLV;
         cursor_byte_ff     <= START_BYTE;
         draw_mode_ff       <= 1'b0;
         bright_level_ff    <= '0;
         column_offset_ff   <= COLUMN_OFFSET_RST;
         brightness_step_ff <= BRIGHTNESS_STEP_RST;
      end else begin
         clr_cnt_ff      <= clr_cnt_in;
         cursor_row_ff   <= cursor_row_in;
         cursor_col_ff   <= cursor_col_in;
         cursor_byte_ff  <= cursor_byte_in;
         draw_mode_ff    <= draw_mode_in;
         bright_level_ff <= bright_level_in;
         if (csr_valid && csr_index == CSR_COLUMN_OFFSET) begin
            column_offset_ff <= csr_wdata[COL_W-1:0];
         end
         if (csr_valid && csr_index == CSR_BRIGHTNESS_STEP) begin
            brightness_step_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         up_ff     <= req_up_pressed;
         down_ff   <= req_down_pressed;
         left_ff   <= req_left_pressed;
         right_ff  <= req_right_pressed;
         toggle_ff <= req_draw_toggle;
         bright_ff <= req_bright_press;
      end
      if (cmd.store) begin
         old_row_ff <= cursor_row_ff;
         old_col_ff <= cursor_col_ff;
      end
      if (cmd.load_new) begin
         kind_ff       <= KIND_CELL;
         page_ff       <= cursor_row_ff[ROW_W-1:ROW_W-PAGE_W];
         column_ff     <= BYTE_W'(cursor_col_ff) + BYTE_W'(column_offset_ff);
         pixels_ff     <= new_pixels;
         brightness_ff <= '0;
         last_ff       <= ~(changed | bright_ff);
      end else if (cmd.load_old) begin
         kind_ff       <= KIND_CELL;
         page_ff       <= old_row_ff[ROW_W-1:ROW_W-PAGE_W];
         column_ff     <= BYTE_W'(old_col_ff) + BYTE_W'(column_offset_ff);
         pixels_ff     <= rd_data_ff;
         brightness_ff <= '0;
         last_ff       <= ~bright_ff;
      end else if (cmd.load_brt) begin
         kind_ff       <= KIND_BRIGHT;
         page_ff       <= '0;
         column_ff     <= '0;
         pixels_ff     <= '0;
         brightness_ff <= bright_level_ff + brightness_step_ff;
         last_ff       <= 1'b1;
      end
   end

   assign status.clear_done = (clr_cnt_ff == LAST_ADDR);
   assign status.move       = up_ff | down_ff | left_ff | right_ff;
   assign status.bright     = bright_ff;
   assign status.changed    = changed;

   assign rsp_kind       = kind_ff;
   assign rsp_page       = page_ff;
   assign rsp_column     = column_ff;
   assign rsp_pixels     = pixels_ff;
   assign rsp_brightness = brightness_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== rtl/core/cursor_pixel_editor_top.sv =====
// Cursor pixel editor top level: button events in, LCD cell and brightness beats out.
// After reset the frame store is cleared, one entry a cycle, all NUM_COLUMNS*NUM_PAGES
// entries (816 by default); req_ready stays low during that pass, csr writes are taken.
// A move event passes ST_DISPATCH, ST_STORE, ST_READ_NEW and ST_LOAD_NEW before its
// first beat; each further beat is presented in the cycle after the previous one is
// taken. Events go one at a time; a move writes the store in draw mode, reads it twice.
module cursor_pixel_editor_top
   import cpe_pkg::*;
#(
   parameter int NUM_COLUMNS = 102,
   parameter int NUM_PAGES   = 8,
   parameter int START_ROW   = 0,
   parameter int START_COL   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_up_pressed,
   input  logic                 req_down_pressed,
   input  logic                 req_left_pressed,
   input  logic                 req_right_pressed,
   input  logic                 req_draw_toggle,
   input  logic                 req_bright_press,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [PAGE_W-1:0]    rsp_page,
   output logic [BYTE_W-1:0]    rsp_column,
   output logic [BYTE_W-1:0]    rsp_pixels,
   output logic [BYTE_W-1:0]    rsp_brightness,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpe_datapath #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .NUM_PAGES   (NUM_PAGES),
      .START_ROW   (START_ROW),
      .START_COL   (START_COL)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_up_pressed    (req_up_pressed),
      .req_down_pressed  (req_down_pressed),
      .req_left_pressed  (req_left_pressed),
      .req_right_pressed (req_right_pressed),
      .req_draw_toggle   (req_draw_toggle),
      .req_bright_press  (req_bright_press),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .status            (status),
      .rsp_kind          (rsp_kind),
      .rsp_page          (rsp_page),
      .rsp_column        (rsp_column),
      .rsp_pixels        (rsp_pixels),
      .rsp_brightness    (rsp_brightness),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== rtl/core/cpe_checker.sv =====
// Port-level assertions for the cursor pixel editor and their bind.
module cpe_checker
   import cpe_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_kind,
   input logic [PAGE_W-1:0] rsp_page,
   input logic [BYTE_W-1:0] rsp_column,
   input logic [BYTE_W-1:0] rsp_pixels,
   input logic [BYTE_W-1:0] rsp_brightness,
   input logic              rsp_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_page)
         && $stable(rsp_column) && $stable(rsp_pixels) && $stable(rsp_brightness)
         && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // one event at a time: no new request while results are pending
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a result is pending");

   a_bright_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BRIGHT |-> rsp_last && rsp_page == '0
         && rsp_column == '0 && rsp_pixels == '0)
      else $error("malformed brightness beat");

   a_cell_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CELL |-> rsp_brightness == '0)
      else $error("cell beat carries brightness");

endmodule

bind cursor_pixel_editor_top cpe_checker u_cpe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_page       (rsp_page),
   .rsp_column     (rsp_column),
   .rsp_pixels     (rsp_pixels),
   .rsp_brightness (rsp_brightness),
   .rsp_last       (rsp_last)
);
